// ===== design/ale_pkg.sv =====
// shared types, command codes and datapath operation codes for the array list engine
// no dependencies
`default_nettype none

package ale_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int CMD_W         = 3;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 10;
    localparam int LEN_W         = 11;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_INSERT   = 3'd0;
    localparam cmd_t CMD_DELETE   = 3'd1;
    localparam cmd_t CMD_LOCATE   = 3'd2;
    localparam cmd_t CMD_RETRIEVE = 3'd3;
    localparam cmd_t CMD_DEDUPE   = 3'd4;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE     = 5'd0;
    localparam op_t OP_START    = 5'd1;
    localparam op_t OP_RD_INS   = 5'd2;
    localparam op_t OP_WR_INS   = 5'd3;
    localparam op_t OP_WR_POS   = 5'd4;
    localparam op_t OP_RD_DEL   = 5'd5;
    localparam op_t OP_WR_DEL   = 5'd6;
    localparam op_t OP_DEL_END  = 5'd7;
    localparam op_t OP_RD_I     = 5'd8;
    localparam op_t OP_LOC_STEP = 5'd9;
    localparam op_t OP_LOC_ABS  = 5'd10;
    localparam op_t OP_RD_POS   = 5'd11;
    localparam op_t OP_RET_END  = 5'd12;
    localparam op_t OP_WORD_LD  = 5'd13;
    localparam op_t OP_RD_J     = 5'd14;
    localparam op_t OP_J_INC    = 5'd15;
    localparam op_t OP_KEEP     = 5'd16;
    localparam op_t OP_SKIP     = 5'd17;
    localparam op_t OP_DDP_END  = 5'd18;
    localparam op_t OP_PUB      = 5'd19;

    typedef struct packed {
        cmd_t cmd;
        logic ins_ok;
        logic pos_lt_cnt;
        logic i_gt_pos;
        logic i_p1_lt_cnt;
        logic i_lt_cnt;
        logic j_lt_kept;
        logic match;
        logic dup;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/ale_req_if.sv =====
// request channel of the array list engine: valid/ready plus command fields
// depends on ale_pkg
`default_nettype none

interface ale_req_if;
    import ale_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== design/ale_rsp_if.sv =====
// result channel of the array list engine: valid/ready plus result fields
// depends on ale_pkg
`default_nettype none

interface ale_rsp_if;
    import ale_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [LEN_W-1:0]         index;
    logic signed [WORD_W-1:0] data;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output ok, output index, output data, output length,
                    input ready);
    modport sink   (input valid, input ok, input index, input data, input length,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ale_dp.sv =====
// datapath: entry memory, list length, walk pointers and the result register
// depends on ale_pkg; driven by ale_ctrl through op codes
`default_nettype none

module ale_dp
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  op_t                      op,
    input  wire [CMD_W-1:0]          in_cmd,
    input  wire signed [WORD_W-1:0]  in_value,
    input  wire [POS_W-1:0]          in_position,
    output stat_t                    stat,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic                     out_ok,
    output logic [LEN_W-1:0]         out_index,
    output logic signed [WORD_W-1:0] out_data,
    output logic [LEN_W-1:0]         out_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic signed [WORD_W-1:0] mem [DEPTH];

    cmd_t                     cmd_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            i_reg;
    logic [CW-1:0]            j_reg;
    logic [CW-1:0]            kept_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] rdata_reg;
    logic                     res_ok_reg;
    logic [CW-1:0]            res_idx_reg;
    logic signed [WORD_W-1:0] res_data_reg;
    logic                     out_valid_reg;
    logic                     out_ok_reg;
    logic [LEN_W-1:0]         out_index_reg;
    logic signed [WORD_W-1:0] out_data_reg;
    logic [LEN_W-1:0]         out_length_reg;

    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            cnt_x;
    logic [XW-1:0]            i_x;
    logic [CW-1:0]            i_p1;
    logic [CW-1:0]            i_m1;

    logic                     re;
    logic [AW-1:0]            raddr;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [WORD_W-1:0] wdata;

    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(cnt_reg);
    assign i_x   = XW'(i_reg);
    assign i_p1  = i_reg + 1'b1;
    assign i_m1  = i_reg - 1'b1;

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.ins_ok      = (cnt_reg < CW'(DEPTH)) && (pos_x <= cnt_x);
        stat.pos_lt_cnt  = pos_x < cnt_x;
        stat.i_gt_pos    = i_x > pos_x;
        stat.i_p1_lt_cnt = i_p1 < cnt_reg;
        stat.i_lt_cnt    = i_reg < cnt_reg;
        stat.j_lt_kept   = j_reg < kept_reg;
        stat.match       = rdata_reg == val_reg;
        stat.dup         = rdata_reg == word_reg;
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    // memory port selection
    always_comb
    begin
        re    = 1'b0;
        raddr = i_reg[AW-1:0];
        we    = 1'b0;
        waddr = i_reg[AW-1:0];
        wdata = rdata_reg;
        unique case (op)
            OP_RD_INS:
            begin
                re    = 1'b1;
                raddr = i_m1[AW-1:0];
            end
            OP_RD_DEL:
            begin
                re    = 1'b1;
                raddr = i_p1[AW-1:0];
            end
            OP_RD_I:
            begin
                re = 1'b1;
            end
            OP_RD_POS:
            begin
                re    = 1'b1;
                raddr = AW'(pos_reg);
            end
            OP_RD_J:
            begin
                re    = 1'b1;
                raddr = j_reg[AW-1:0];
            end
            OP_WR_INS, OP_WR_DEL:
            begin
                we = 1'b1;
            end
            OP_WR_POS:
            begin
                we    = 1'b1;
                waddr = AW'(pos_reg);
                wdata = val_reg;
            end
            OP_KEEP:
            begin
                we    = 1'b1;
                waddr = kept_reg[AW-1:0];
                wdata = word_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // request fields and working registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_START:
            begin
                cmd_reg      <= in_cmd;
                val_reg      <= in_value;
                pos_reg      <= in_position;
                i_reg        <= (in_cmd == CMD_INSERT) ? cnt_reg :
                                (in_cmd == CMD_DELETE) ? CW'(in_position) : '0;
                j_reg        <= '0;
                kept_reg     <= '0;
                res_ok_reg   <= (in_cmd == CMD_LOCATE) || (in_cmd == CMD_DEDUPE);
                res_idx_reg  <= '0;
                res_data_reg <= '0;
            end
            OP_WR_INS:   i_reg <= i_m1;
            OP_WR_DEL:   i_reg <= i_p1;
            OP_WR_POS, OP_DEL_END: res_ok_reg <= 1'b1;
            OP_LOC_STEP:
            begin
                if (rdata_reg == val_reg)
                begin
                    res_idx_reg <= i_reg;
                end
                else
                begin
                    i_reg <= i_p1;
                end
            end
            OP_LOC_ABS:  res_idx_reg <= cnt_reg;
            OP_RET_END:
            begin
                res_ok_reg   <= 1'b1;
                res_data_reg <= rdata_reg;
            end
            OP_WORD_LD:
            begin
                word_reg <= rdata_reg;
                j_reg    <= '0;
            end
            OP_J_INC:    j_reg <= j_reg + 1'b1;
            OP_KEEP:
            begin
                kept_reg <= kept_reg + 1'b1;
                i_reg    <= i_p1;
            end
            OP_SKIP:     i_reg <= i_p1;
            default:
            begin
            end
        endcase
    end

    // list length and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_WR_POS:  cnt_reg <= cnt_reg + 1'b1;
                OP_DEL_END: cnt_reg <= cnt_reg - 1'b1;
                OP_DDP_END: cnt_reg <= kept_reg;
                OP_PUB:     out_valid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_PUB)
        begin
            out_ok_reg     <= res_ok_reg;
            out_index_reg  <= LEN_W'(res_idx_reg);
            out_data_reg   <= res_data_reg;
            out_length_reg <= LEN_W'(cnt_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_ok     = out_ok_reg;
    assign out_index  = out_index_reg;
    assign out_data   = out_data_reg;
    assign out_length = out_length_reg;

endmodule

`default_nettype wire

// ===== design/ale_ctrl.sv =====
// controller: sequences the shift, search and dedupe walks over the datapath
// depends on ale_pkg; drives ale_dp with one op code per cycle
`default_nettype none

module ale_ctrl
    import ale_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output op_t   op
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISP     = 4'd1;
    localparam logic [3:0] ST_INS_LOOP = 4'd2;
    localparam logic [3:0] ST_INS_WR   = 4'd3;
    localparam logic [3:0] ST_DEL_LOOP = 4'd4;
    localparam logic [3:0] ST_DEL_WR   = 4'd5;
    localparam logic [3:0] ST_LOC_RD   = 4'd6;
    localparam logic [3:0] ST_LOC_CMP  = 4'd7;
    localparam logic [3:0] ST_RET_RD   = 4'd8;
    localparam logic [3:0] ST_RET_END  = 4'd9;
    localparam logic [3:0] ST_DDP_RD   = 4'd10;
    localparam logic [3:0] ST_DDP_LD   = 4'd11;
    localparam logic [3:0] ST_DDP_J    = 4'd12;
    localparam logic [3:0] ST_DDP_JCMP = 4'd13;
    localparam logic [3:0] ST_FIN      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_START;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (stat.cmd)
                    CMD_INSERT:   state_next = stat.ins_ok ? ST_INS_LOOP : ST_FIN;
                    CMD_DELETE:   state_next = stat.pos_lt_cnt ? ST_DEL_LOOP : ST_FIN;
                    CMD_LOCATE:   state_next = ST_LOC_RD;
                    CMD_RETRIEVE: state_next = stat.pos_lt_cnt ? ST_RET_RD : ST_FIN;
                    CMD_DEDUPE:   state_next = ST_DDP_RD;
                    default:      state_next = ST_FIN;
                endcase
            end
            ST_INS_LOOP:
            begin
                if (stat.i_gt_pos)
                begin
                    op         = OP_RD_INS;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    op         = OP_WR_POS;
                    state_next = ST_FIN;
                end
            end
            ST_INS_WR:
            begin
                op         = OP_WR_INS;
                state_next = ST_INS_LOOP;
            end
            ST_DEL_LOOP:
            begin
                if (stat.i_p1_lt_cnt)
                begin
                    op         = OP_RD_DEL;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    op         = OP_DEL_END;
                    state_next = ST_FIN;
                end
            end
            ST_DEL_WR:
            begin
                op         = OP_WR_DEL;
                state_next = ST_DEL_LOOP;
            end
            ST_LOC_RD:
            begin
                if (stat.i_lt_cnt)
                begin
                    op         = OP_RD_I;
                    state_next = ST_LOC_CMP;
                end
                else
                begin
                    op         = OP_LOC_ABS;
                    state_next = ST_FIN;
                end
            end
            ST_LOC_CMP:
            begin
                op         = OP_LOC_STEP;
                state_next = stat.match ? ST_FIN : ST_LOC_RD;
            end
            ST_RET_RD:
            begin
                op         = OP_RD_POS;
                state_next = ST_RET_END;
            end
            ST_RET_END:
            begin
                op         = OP_RET_END;
                state_next = ST_FIN;
            end
            ST_DDP_RD:
            begin
                if (stat.i_lt_cnt)
                begin
                    op         = OP_RD_I;
                    state_next = ST_DDP_LD;
                end
                else
                begin
                    op         = OP_DDP_END;
                    state_next = ST_FIN;
                end
            end
            ST_DDP_LD:
            begin
                op         = OP_WORD_LD;
                state_next = ST_DDP_J;
            end
            // search the kept prefix for the current word
            ST_DDP_J:
            begin
                if (stat.j_lt_kept)
                begin
                    op         = OP_RD_J;
                    state_next = ST_DDP_JCMP;
                end
                else
                begin
                    op         = OP_KEEP;
                    state_next = ST_DDP_RD;
                end
            end
            ST_DDP_JCMP:
            begin
                if (stat.dup)
                begin
                    op         = OP_SKIP;
                    state_next = ST_DDP_RD;
                end
                else
                begin
                    op         = OP_J_INC;
                    state_next = ST_DDP_J;
                end
            end
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_PUB;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/array_list_engine_top.sv =====
// Array list engine: an ordered list of signed 32-bit words kept in a single-port-read,
// single-port-write memory of DEPTH entries plus a length register. One request is worked
// at a time and each gives one result. Insert and delete move one entry at a time, reading
// it and then writing it to its neighbouring place; locate reads and compares one entry at
// a time; remove duplicates compares each entry with the kept prefix. The result register
// lets a new request be taken while the previous result waits; a request that finishes
// while that result is still waiting holds in its final state until the result is taken.
// depends on ale_pkg, ale_req_if, ale_rsp_if, ale_ctrl, ale_dp
`default_nettype none

module array_list_engine_top
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire        clk,
    input  wire        rst_n,
    ale_req_if.sink    req,
    ale_rsp_if.source  rsp
);

    op_t   op;
    stat_t stat;

    ale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .op        (op)
    );

    ale_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .in_cmd      (req.cmd),
        .in_value    (req.value),
        .in_position (req.position),
        .stat        (stat),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_ok      (rsp.ok),
        .out_index   (rsp.index),
        .out_data    (rsp.data),
        .out_length  (rsp.length)
    );

endmodule

`default_nettype wire

// ===== sim/array_list_engine_top_test.sv =====
// testbench for array_list_engine_top: directed and random list commands with a
// list model and in-order result checking
// depends on ale_pkg, ale_req_if, ale_rsp_if and the design files
`timescale 1ns / 100ps

module array_list_engine_top_test;
    import ale_pkg::*;

    localparam int LIST_MAX = DEPTH_DEFAULT;

    typedef struct {
        logic             ok;
        logic [LEN_W-1:0] index;
        logic [31:0]      data;
        logic [LEN_W-1:0] length;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ale_req_if req ();
    ale_rsp_if rsp ();

    array_list_engine_top uut (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    always #5 clk = ~clk;

    // list model
    logic [31:0] words[LIST_MAX];
    int          word_count;
    outcome_t    pending_outcomes[$];

    int  fail_count;
    int  send_gap_pct;
    int  take_gap_pct;
    longint cycle_count;

    function automatic outcome_t apply_command(cmd_t c, logic [31:0] v, logic [POS_W-1:0] p);
        outcome_t o;
        int i;
        int k;
        int kept;
        bit seen;
        o = '{ok: 1'b0, index: '0, data: '0, length: '0};
        case (c)
            CMD_INSERT:
                if (word_count < LIST_MAX && p <= word_count)
                begin
                    for (i = word_count; i > p; i--)
                        words[i] = words[i-1];
                    words[p] = v;
                    word_count++;
                    o.ok = 1'b1;
                end
            CMD_DELETE:
                if (p < word_count)
                begin
                    for (i = p; i + 1 < word_count; i++)
                        words[i] = words[i+1];
                    word_count--;
                    o.ok = 1'b1;
                end
            CMD_LOCATE:
            begin
                o.index = LEN_W'(word_count);
                for (i = word_count - 1; i >= 0; i--)
                    if (words[i] == v)
                        o.index = LEN_W'(i);
                o.ok = 1'b1;
            end
            CMD_RETRIEVE:
                if (p < word_count)
                begin
                    o.data = words[p];
                    o.ok = 1'b1;
                end
            CMD_DEDUPE:
            begin
                kept = 0;
                for (i = 0; i < word_count; i++)
                begin
                    seen = 1'b0;
                    for (k = 0; k < kept; k++)
                        if (words[k] == words[i])
                            seen = 1'b1;
                    if (!seen)
                    begin
                        words[kept] = words[i];
                        kept++;
                    end
                end
                word_count = kept;
                o.ok = 1'b1;
            end
            default: ;
        endcase
        o.length = LEN_W'(word_count);
        return o;
    endfunction

    // valid stays high when the next request follows at once
    task automatic send_request(cmd_t c, logic [31:0] v, logic [POS_W-1:0] p);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.value <= v;
        req.position <= p;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_outcomes.push_back(apply_command(c, v, p));
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        outcome_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t unexpected result ok=%0d length=%0d", $time, rsp.ok, rsp.length);
                fail_count++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (rsp.ok !== e.ok || rsp.index !== e.index || rsp.data !== e.data
                    || rsp.length !== e.length)
                begin
                    $display("%0t mismatch: expected ok=%0d index=%0d data=%h length=%0d",
                             $time, e.ok, e.index, e.data, e.length);
                    $display("%0t           actual   ok=%0d index=%0d data=%h length=%0d",
                             $time, rsp.ok, rsp.index, rsp.data, rsp.length);
                    fail_count++;
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= take_gap_pct);
    end

    always @(posedge clk)
        if (cycle_count > 4000000)
        begin
            $display("tb: failure");
            $finish;
        end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(6);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(CMD_RETRIEVE, 0, 0);
        send_request(CMD_DELETE, 0, 0);
        send_request(CMD_LOCATE, 32'h1234, 0);
        send_request(CMD_DEDUPE, 0, 0);
        send_request(CMD_INSERT, 32'h8000_0000, 0);
        send_request(CMD_INSERT, 32'h7fff_ffff, 1);
        send_request(CMD_INSERT, 32'hffff_ffff, 3);
        send_request(CMD_INSERT, 32'hffff_ffff, 0);
        send_request(CMD_INSERT, 32'h8000_0000, 2);
        send_request(CMD_INSERT, 0, 10'h3ff);
        send_request(CMD_LOCATE, 32'h8000_0000, 0);
        send_request(CMD_LOCATE, 32'h5555_aaaa, 0);
        send_request(CMD_RETRIEVE, 0, 3);
        send_request(CMD_RETRIEVE, 0, 4);
        send_request(CMD_RETRIEVE, 0, 10'h3ff);
        send_request(CMD_DEDUPE, 0, 0);
        send_request(CMD_DELETE, 0, 2);
        send_request(CMD_DELETE, 0, 10'h3ff);
        send_request(3'd5, 32'hffff_ffff, 10'h3ff);
        send_request(3'd6, 0, 0);
        send_request(3'd7, 32'ha5a5_5a5a, 10'h2aa);
    endtask

    task automatic test_random(int n);
        int r;
        cmd_t c;
        logic [POS_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                c = CMD_INSERT;
            else if (r < 55)
                c = CMD_DELETE;
            else if (r < 72)
                c = CMD_LOCATE;
            else if (r < 90)
                c = CMD_RETRIEVE;
            else if (r < 94)
                c = CMD_DEDUPE;
            else
                c = cmd_t'($urandom_range(7));
            if ($urandom_range(9) == 0)
                p = POS_W'($urandom);
            else
                p = POS_W'($urandom_range(word_count + 1));
            send_request(c, pick_word(), p);
        end
    endtask

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        word_count = 0;
        send_gap_pct = 27;
        take_gap_pct = 46;
        req.valid = 1'b0;
        req.cmd = '0;
        req.value = '0;
        req.position = '0;
        rsp.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        send_gap_pct = 46;
        take_gap_pct = 27;
        test_random(180);
        send_gap_pct = 0;
        take_gap_pct = 0;
        test_random(180);
        req.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
